[src/izs_pkg.sv]
// Shared types, constants and the microcode program of the irrigation zone sequencer.
// Depends on nothing; every other file of the block imports it.
package izs_pkg;

    localparam int MAX_ZONES   = 16;
    localparam int TICK_W      = 16;
    localparam int ZCOUNT_W    = 5;
    localparam int ZIDX_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int PCT_W       = 7;
    localparam int ACTION_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = TICK_W + PCT_W;
    localparam int DIV_STEPS   = PCT_W;
    localparam int DIV_CNT_W   = 3;
    localparam int UPC_W       = 3;

    localparam logic [TICK_W-1:0]   ZONE_RUN_TICKS_RST    = 16'd1200;
    localparam logic [TICK_W-1:0]   BUTTON_HOLD_TICKS_RST = 16'd200;
    localparam logic [ZCOUNT_W-1:0] ZONE_COUNT_RST        = 5'd10;
    localparam logic [PCT_W-1:0]    PCT_FULL              = 7'd100;
    localparam logic [TICK_W-1:0]   HOLD_MAX              = 16'hFFFF;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 3'd0,
        ACT_ENABLE  = 3'd1,
        ACT_DISABLE = 3'd2,
        ACT_PAUSE   = 3'd3,
        ACT_RESUME  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_IDLE   = 2'd0,
        STAT_ACTIVE = 2'd1,
        STAT_PAUSED = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZONE_RUN_TICKS    = 2'd0,
        REG_BUTTON_HOLD_TICKS = 2'd1,
        REG_ZONE_COUNT        = 2'd2
    } reg_idx_t;

    // Datapath operation selected by one microcode word.
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_FETCH,
        UOP_MUL,
        UOP_DIV_LOAD,
        UOP_DIV_STEP,
        UOP_EMIT
    } uop_t;

    // Jump condition: when true, the step counter loads the target, else it counts up.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        upc_t  target;
    } ctrl_word_t;

    localparam upc_t STEP_FETCH = 3'd0;
    localparam upc_t STEP_MUL   = 3'd1;
    localparam upc_t STEP_LOAD  = 3'd2;
    localparam upc_t STEP_DIV   = 3'd3;
    localparam upc_t STEP_EMIT  = 3'd4;
    localparam upc_t STEP_BACK  = 3'd5;

    function automatic ctrl_word_t ucode_rom(input upc_t pc);
        ctrl_word_t w;
        begin
            unique case (pc)
                STEP_FETCH: w = '{UOP_FETCH,    COND_NO_INPUT, STEP_FETCH};
                STEP_MUL:   w = '{UOP_MUL,      COND_NEVER,    STEP_FETCH};
                STEP_LOAD:  w = '{UOP_DIV_LOAD, COND_NEVER,    STEP_FETCH};
                STEP_DIV:   w = '{UOP_DIV_STEP, COND_DIV_MORE, STEP_DIV};
                STEP_EMIT:  w = '{UOP_EMIT,     COND_OUT_BUSY, STEP_EMIT};
                default:    w = '{UOP_NOP,      COND_ALWAYS,   STEP_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage

[src/izs_if.sv]
// Valid/ready channel interfaces of the irrigation zone sequencer: input, result, config.
// Depends on izs_pkg for field widths.
interface izs_in_if import izs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                stop_button;

    modport source (output valid, output action, output stop_button, input ready);
    modport sink   (input valid, input action, input stop_button, output ready);
endinterface

interface izs_out_if import izs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MAX_ZONES-1:0] relay_on;
    logic [STATUS_W-1:0]  run_status;
    logic [ZCOUNT_W-1:0]  zone_number;
    logic [PCT_W-1:0]     percent_done;
    logic                 enable_refused;

    modport source (output valid, output relay_on, output run_status,
                    output zone_number, output percent_done, output enable_refused,
                    input ready);
    modport sink   (input valid, input relay_on, input run_status,
                    input zone_number, input percent_done, input enable_refused,
                    output ready);
endinterface

interface izs_cfg_if import izs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TICK_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/irrigation_zone_sequencer.sv]
// Irrigation zone sequencer top level: microcode sequencer, zone state and percent divider.
// Depends on izs_pkg and the channel interfaces in izs_if.sv.

// Every accepted beat on in_ch produces exactly one result beat on out_ch. The block works on
// one item at a time and runs these microcode steps per item: one fetch step in which the item
// is accepted and the zone state is updated, one step for the 16 x 7 bit multiply of the zone
// ticks by 100, one step to load the divider, seven steps of restoring division (one quotient
// bit each), one step to load the output register and one step to return to fetch. The result
// sits in an output register, so a new item is accepted while the previous result still waits;
// the emit step stalls only when that register is still full. Configuration writes are always
// taken (cfg.ready is tied high) and must only be issued while no item is in flight. After
// reset the zone time is 1200 ticks, the button hold time 200 ticks and ten zones are in use.
module irrigation_zone_sequencer
    import izs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    izs_in_if.sink      in_ch,
    izs_out_if.source   out_ch,
    izs_cfg_if.sink     cfg
);

    // Configuration registers.
    logic [TICK_W-1:0]   zone_run_ticks_reg;
    logic [TICK_W-1:0]   button_hold_ticks_reg;
    logic [ZCOUNT_W-1:0] zone_count_reg;

    // Zone state.
    logic                 run_reg, run_next;
    logic                 paused_reg, paused_next;
    logic                 started_reg, started_next;
    logic [TICK_W-1:0]    ticks_reg, ticks_next;
    logic [ZIDX_W-1:0]    idx_reg, idx_next;
    logic [TICK_W-1:0]    hold_reg, hold_next;
    logic [MAX_ZONES-1:0] relay_reg, relay_next;
    logic                 refused_reg, refused_next;

    // Microcode sequencer.
    upc_t       upc_reg, upc_next;
    ctrl_word_t cw;
    logic       cond_true;

    // Percent datapath.
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    rem_reg;
    logic [PROD_W-1:0]    dsh_reg;
    logic [PCT_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 sat_reg;
    logic [PCT_W-1:0]     percent;
    logic                 rem_ge;

    // Output register.
    logic                 out_valid_reg;
    logic [MAX_ZONES-1:0] out_relay_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [ZCOUNT_W-1:0]  out_zone_reg;
    logic [PCT_W-1:0]     out_pct_reg;
    logic                 out_refused_reg;

    logic                 accept;
    logic                 out_free;
    logic                 emit;
    logic [ZCOUNT_W-1:0]  zone_lim;
    status_t              status;

    assign cw       = ucode_rom(upc_reg);
    assign in_ch.ready = (cw.uop == UOP_FETCH);
    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit     = (cw.uop == UOP_EMIT) && out_free;
    assign cfg.ready = 1'b1;

    // A zone count of zero acts as one, anything above the relay width as the full width.
    always_comb
    begin
        if (zone_count_reg == '0)
            zone_lim = ZCOUNT_W'(1);
        else if (zone_count_reg > ZCOUNT_W'(MAX_ZONES))
            zone_lim = ZCOUNT_W'(MAX_ZONES);
        else
            zone_lim = zone_count_reg;
    end

    // Step counter: a true jump condition loads the target, otherwise the next step follows.
    always_comb
    begin
        unique case (cw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_INPUT: cond_true = !in_ch.valid;
            COND_DIV_MORE: cond_true = (cnt_reg != DIV_CNT_W'(DIV_STEPS - 1));
            COND_OUT_BUSY: cond_true = !out_free;
            default:       cond_true = 1'b1;
        endcase
        upc_next = cond_true ? cw.target : upc_t'(upc_reg + upc_t'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= STEP_FETCH;
        else
            upc_reg <= upc_next;
    end

    // Configuration writes. Indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_run_ticks_reg    <= ZONE_RUN_TICKS_RST;
            button_hold_ticks_reg <= BUTTON_HOLD_TICKS_RST;
            zone_count_reg        <= ZONE_COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_ZONE_RUN_TICKS:    zone_run_ticks_reg    <= cfg.data;
                REG_BUTTON_HOLD_TICKS: button_hold_ticks_reg <= cfg.data;
                REG_ZONE_COUNT:        zone_count_reg        <= cfg.data[ZCOUNT_W-1:0];
                default:               ;
            endcase
        end
    end

    // Zone state update for the accepted item. The stop button is handled before the run
    // logic, and a cycle reset at the end of the last zone leaves the hold counter alone.
    always_comb
    begin
        run_next     = run_reg;
        paused_next  = paused_reg;
        started_next = started_reg;
        ticks_next   = ticks_reg;
        idx_next     = idx_reg;
        hold_next    = hold_reg;
        relay_next   = relay_reg;
        refused_next = refused_reg;
        if (accept)
        begin
            refused_next = 1'b0;
            unique case (action_t'(in_ch.action))
                ACT_TICK:
                begin
                    if (in_ch.stop_button)
                    begin
                        if (hold_next >= button_hold_ticks_reg)
                        begin
                            relay_next   = '0;
                            run_next     = 1'b0;
                            started_next = 1'b0;
                            ticks_next   = '0;
                            idx_next     = '0;
                            paused_next  = 1'b0;
                            hold_next    = '0;
                        end
                        if (hold_next != HOLD_MAX)
                            hold_next = hold_next + TICK_W'(1);
                    end
                    else
                    begin
                        hold_next = '0;
                    end
                    if (run_next)
                    begin
                        if (!started_next)
                        begin
                            started_next = 1'b1;
                            relay_next   = relay_next | (MAX_ZONES'(1) << idx_next);
                        end
                        else if (ticks_next >= zone_run_ticks_reg)
                        begin
                            ticks_next = '0;
                            relay_next = relay_next & ~(MAX_ZONES'(1) << idx_next);
                            // The last zone is done: the whole cycle resets.
                            if (({1'b0, idx_next} + ZCOUNT_W'(1)) >= zone_lim)
                            begin
                                relay_next   = '0;
                                run_next     = 1'b0;
                                started_next = 1'b0;
                                idx_next     = '0;
                                paused_next  = 1'b0;
                            end
                            else
                            begin
                                idx_next   = idx_next + ZIDX_W'(1);
                                relay_next = relay_next | (MAX_ZONES'(1) << idx_next);
                            end
                        end
                        else
                        begin
                            ticks_next = ticks_next + TICK_W'(1);
                        end
                    end
                end
                ACT_ENABLE:
                begin
                    if (!paused_reg)
                        run_next = 1'b1;
                    else
                        refused_next = 1'b1;
                end
                ACT_DISABLE:
                begin
                    relay_next   = '0;
                    run_next     = 1'b0;
                    started_next = 1'b0;
                    ticks_next   = '0;
                    idx_next     = '0;
                    paused_next  = 1'b0;
                end
                ACT_PAUSE:
                begin
                    run_next    = 1'b0;
                    relay_next  = '0;
                    paused_next = 1'b1;
                end
                ACT_RESUME:
                begin
                    paused_next = 1'b0;
                    run_next    = 1'b1;
                    relay_next  = relay_reg | (MAX_ZONES'(1) << idx_reg);
                end
                default:
                begin
                    // Unknown codes change no zone state and just report the status.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            paused_reg  <= 1'b0;
            started_reg <= 1'b0;
            ticks_reg   <= '0;
            idx_reg     <= '0;
            hold_reg    <= '0;
            relay_reg   <= '0;
            refused_reg <= 1'b0;
        end
        else
        begin
            run_reg     <= run_next;
            paused_reg  <= paused_next;
            started_reg <= started_next;
            ticks_reg   <= ticks_next;
            idx_reg     <= idx_next;
            hold_reg    <= hold_next;
            relay_reg   <= relay_next;
            refused_reg <= refused_next;
        end
    end

    // Percent divider. The product is checked against the zone time scaled by 128 first; when
    // it is at least that large the quotient is far above 100 and saturates, which also covers
    // a zone time of zero. Otherwise seven restoring steps give the 7-bit quotient.
    assign rem_ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        unique case (cw.uop)
            UOP_MUL:
            begin
                prod_reg <= PROD_W'({{PCT_W{1'b0}}, ticks_reg} * PROD_W'(PCT_FULL));
            end
            UOP_DIV_LOAD:
            begin
                sat_reg <= (prod_reg >= {zone_run_ticks_reg, {PCT_W{1'b0}}});
                rem_reg <= prod_reg;
                dsh_reg <= {1'b0, zone_run_ticks_reg, {(PCT_W-1){1'b0}}};
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            UOP_DIV_STEP:
            begin
                if (rem_ge)
                    rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[PCT_W-2:0], rem_ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (sat_reg || (quo_reg > PCT_FULL))
            percent = PCT_FULL;
        else
            percent = quo_reg;
        if (run_reg)
            status = STAT_ACTIVE;
        else if (paused_reg)
            status = STAT_PAUSED;
        else
            status = STAT_IDLE;
    end

    // Output register: loaded at the emit step, cleared when the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_relay_reg   <= relay_reg;
            out_status_reg  <= status;
            out_zone_reg    <= {1'b0, idx_reg} + ZCOUNT_W'(1);
            out_pct_reg     <= percent;
            out_refused_reg <= refused_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.relay_on       = out_relay_reg;
    assign out_ch.run_status     = out_status_reg;
    assign out_ch.zone_number    = out_zone_reg;
    assign out_ch.percent_done   = out_pct_reg;
    assign out_ch.enable_refused = out_refused_reg;

`ifndef SYNTH
    // At most one valve is ever energized.
    a_one_relay: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(relay_reg))
        else $error("more than one zone relay energized");

    // Running and paused never hold together.
    a_run_pause: assert property (@(posedge clk) disable iff (!rst_n)
        !(run_reg && paused_reg))
        else $error("run and pause flags both set");

    // Zone time only counts once a cycle has started.
    a_ticks_start: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (ticks_reg == '0))
        else $error("zone ticks counted before cycle start");

    // An accepted item always proceeds to the multiply step.
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (upc_reg == STEP_MUL))
        else $error("sequencer did not advance after accept");

    // A reported percentage never exceeds a full zone.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pct_reg <= PCT_FULL))
        else $error("percent above 100 reported");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the irrigation zone sequencer: directed and random beats,
// a clocked driver and monitor, and a cycle-accurate-free predictor of every result.
// Depends on izs_pkg, the channel interfaces in izs_if.sv and the block itself.
module testbench;
    import izs_pkg::*;

    // Codes 5 to 7 are not assigned; the block must answer them with a plain status result.
    localparam logic [ACTION_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_LAST  = 3'd7;

    // Longest stretch without any accepted beat that a correct run can show. It must exceed
    // the receiver hold-off (HOLDOFF_LEN) and the pauses around register writes (SETTLE_LEN).
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLDOFF_LEN  = 300;
    localparam int SETTLE_LEN   = 20;
    localparam int MAX_REPORTS  = 10;

    // One command or tick beat waiting to be offered to the block.
    typedef struct {
        logic [ACTION_W-1:0] action;
        logic                stop;
    } zone_cmd_t;

    // One status beat as the block reports it.
    typedef struct packed {
        logic [MAX_ZONES-1:0] relays;
        status_t              status;
        logic [ZCOUNT_W-1:0]  zone;
        logic [PCT_W-1:0]     pct;
        logic                 refused;
    } zone_report_t;

    logic clk = 1'b0;
    logic rst_n;

    izs_in_if  in_ch ();
    izs_out_if out_ch ();
    izs_cfg_if cfg ();

    irrigation_zone_sequencer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Beats still to be offered, and the status reports the block still owes us.
    zone_cmd_t    pending_cmds[$];
    zone_report_t owed_reports[$];

    // Register values as the block should hold them. Only the stimulus process writes these,
    // and only while nothing is in flight.
    logic [TICK_W-1:0]   shadow_zone_time = ZONE_RUN_TICKS_RST;
    logic [TICK_W-1:0]   shadow_hold_time = BUTTON_HOLD_TICKS_RST;
    logic [ZCOUNT_W-1:0] shadow_zone_count = ZONE_COUNT_RST;

    // Sequencer state as the predictor tracks it.
    logic                seq_running = 1'b0;
    logic                seq_paused = 1'b0;
    logic                seq_started = 1'b0;
    logic [TICK_W-1:0]   seq_ticks = '0;
    logic [ZIDX_W-1:0]   seq_zone = '0;
    logic [TICK_W-1:0]   seq_hold = '0;
    logic [MAX_ZONES-1:0] seq_relays = '0;

    int   fail_count = 0;
    int   idle_cycles = 0;
    logic in_taken = 1'b0;

    // Knobs the stimulus process turns. calm switches all random idling off; bumping
    // holdoff_asked makes the receiver refuse results for a long stretch.
    logic calm = 1'b0;
    int   holdoff_asked = 0;
    int   holdoff_seen = 0;
    int   holdoff_left = 0;

    // A cycle reset stops the run and clears the zone position; the button hold count
    // survives it.
    function automatic void clear_cycle();
        seq_relays  = '0;
        seq_running = 1'b0;
        seq_started = 1'b0;
        seq_ticks   = '0;
        seq_zone    = '0;
        seq_paused  = 1'b0;
    endfunction

    // Apply one accepted beat to the tracked state and work out the report it causes.
    task automatic predict_report(input logic [ACTION_W-1:0] act, input logic stop,
                                  output zone_report_t rep);
        logic                refused;
        logic [ZCOUNT_W-1:0] next_zone;
        logic [ZCOUNT_W-1:0] zones_used;
        int unsigned         ratio;
        refused = 1'b0;
        // A zone count of zero still runs one zone; anything past the relay width is clamped.
        if (shadow_zone_count == 0)
            zones_used = 5'd1;
        else if (shadow_zone_count > MAX_ZONES)
            zones_used = 5'(MAX_ZONES);
        else
            zones_used = shadow_zone_count;

        case (act)
            ACT_TICK:
            begin
                // The button is looked at before the run logic. A long enough hold forces
                // the cycle reset and restarts the hold count from one.
                if (stop)
                begin
                    if (seq_hold >= shadow_hold_time)
                    begin
                        clear_cycle();
                        seq_hold = '0;
                    end
                    if (seq_hold != HOLD_MAX)
                        seq_hold = seq_hold + 1'b1;
                end
                else
                begin
                    seq_hold = '0;
                end

                if (seq_running)
                begin
                    if (!seq_started)
                    begin
                        seq_started = 1'b1;
                        seq_relays  = seq_relays | (16'h1 << seq_zone);
                    end
                    else if (seq_ticks >= shadow_zone_time)
                    begin
                        // The index is widened so that the last of sixteen zones wraps
                        // into the cycle reset rather than back to zone one.
                        seq_ticks  = '0;
                        seq_relays = seq_relays & ~(16'h1 << seq_zone);
                        next_zone  = {1'b0, seq_zone} + 5'd1;
                        if (next_zone >= zones_used)
                        begin
                            clear_cycle();
                        end
                        else
                        begin
                            seq_zone   = next_zone[ZIDX_W-1:0];
                            seq_relays = seq_relays | (16'h1 << seq_zone);
                        end
                    end
                    else
                    begin
                        seq_ticks = seq_ticks + 1'b1;
                    end
                end
            end
            ACT_ENABLE:
            begin
                if (!seq_paused)
                    seq_running = 1'b1;
                else
                    refused = 1'b1;
            end
            ACT_DISABLE:
            begin
                clear_cycle();
            end
            ACT_PAUSE:
            begin
                seq_running = 1'b0;
                seq_relays  = '0;
                seq_paused  = 1'b1;
            end
            ACT_RESUME:
            begin
                // Resume works from any state and always powers the current zone.
                seq_paused  = 1'b0;
                seq_running = 1'b1;
                seq_relays  = seq_relays | (16'h1 << seq_zone);
            end
            default:
            begin
            end
        endcase

        rep.relays  = seq_relays;
        rep.status  = seq_running ? STAT_ACTIVE : (seq_paused ? STAT_PAUSED : STAT_IDLE);
        rep.zone    = {1'b0, seq_zone} + 5'd1;
        rep.refused = refused;
        // A zone time of zero reads as complete; a zone time lowered mid-zone can push the
        // ratio past full, which is clamped.
        if (shadow_zone_time == 0)
        begin
            rep.pct = PCT_FULL;
        end
        else
        begin
            ratio = (32'(seq_ticks) * 32'd100) / 32'(shadow_zone_time);
            if (ratio > 32'(PCT_FULL))
                ratio = 32'(PCT_FULL);
            rep.pct = ratio[PCT_W-1:0];
        end
    endtask

    // Driver: a new beat is offered at the falling edge once the previous one was taken.
    // The valid line is written only at falling edges where no beat waits or the last was taken.
    always @(negedge clk)
    begin : drive_cmds
        zone_cmd_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_taken)
        begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 6))
            begin
                nxt = pending_cmds.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.action      <= nxt.action;
                in_ch.stop_button <= nxt.stop;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: ready changes at the falling edge. A hold-off request blocks results until
    // holdoff_left, loaded from HOLDOFF_LEN, has run down to zero, while the driver keeps offering beats.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (holdoff_seen != holdoff_asked)
        begin
            holdoff_seen <= holdoff_asked;
            holdoff_left <= HOLDOFF_LEN;
            out_ch.ready <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // Monitor: both channels are sampled at the rising edge. The result is checked before
    // the accepted input beat is predicted, so the queue order never depends on the
    // scheduler.
    always @(posedge clk)
    begin : observe
        zone_report_t got;
        zone_report_t want;
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.relays  = out_ch.relay_on;
                got.status  = status_t'(out_ch.run_status);
                got.zone    = out_ch.zone_number;
                got.pct     = out_ch.percent_done;
                got.refused = out_ch.enable_refused;
                if (owed_reports.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result beat at %0t: relays %h", $realtime,
                                 got.relays);
                end
                else
                begin
                    want = owed_reports.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= MAX_REPORTS)
                            $display({"mismatch at %0t: relays %h/%h status %0d/%0d ",
                                      "zone %0d/%0d pct %0d/%0d refused %b/%b ",
                                      "(expected/actual)"}, $realtime,
                                     want.relays, got.relays, want.status, got.status,
                                     want.zone, got.zone, want.pct, got.pct,
                                     want.refused, got.refused);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predict_report(in_ch.action, in_ch.stop_button, want);
                owed_reports.push_back(want);
            end
        end
    end

    // Watchdog: ends the run when no beat at all has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_cmd(input logic [ACTION_W-1:0] act, input logic stop);
        zone_cmd_t c;
        c.action = act;
        c.stop   = stop;
        pending_cmds.push_back(c);
    endtask

    // Wait until every beat was offered, taken and answered.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_cmds.size() != 0 || owed_reports.size() != 0 || in_ch.valid)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [TICK_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_ZONE_RUN_TICKS:    shadow_zone_time  = value;
            REG_BUTTON_HOLD_TICKS: shadow_hold_time  = value;
            default:               shadow_zone_count = value[ZCOUNT_W-1:0];
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Registers change only with the block at rest; the pause lets the last item's
    // microcode finish its return to fetch.
    task automatic set_registers(input logic [TICK_W-1:0] zone_time,
                                 input logic [TICK_W-1:0] hold_time,
                                 input logic [ZCOUNT_W-1:0] zones);
        wait_drained();
        repeat (SETTLE_LEN) @(posedge clk);
        write_reg(REG_ZONE_RUN_TICKS, zone_time);
        write_reg(REG_BUTTON_HOLD_TICKS, hold_time);
        write_reg(REG_ZONE_COUNT, {11'd0, zones});
    endtask

    // Mostly ticks so that zones really advance, with occasional button presses held around a
    // low hold threshold, a mix of commands and a little noise from unused codes.
    task automatic queue_traffic(input int count);
        int roll;
        int press_left;
        int press_cap;
        press_left = 0;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 72)
            begin
                if (press_left == 0 && $urandom_range(24) == 0)
                begin
                    press_cap  = (shadow_hold_time > 16) ? 20 : int'(shadow_hold_time) + 3;
                    press_left = $urandom_range(press_cap, 1);
                end
                queue_cmd(ACT_TICK, press_left != 0);
                if (press_left != 0)
                    press_left = press_left - 1;
            end
            else if (roll < 82)
                queue_cmd(ACT_ENABLE, 1'($urandom));
            else if (roll < 86)
                queue_cmd(ACT_DISABLE, 1'($urandom));
            else if (roll < 91)
                queue_cmd(ACT_PAUSE, 1'($urandom));
            else if (roll < 97)
                queue_cmd(ACT_RESUME, 1'($urandom));
            else
                queue_cmd(3'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST)), 1'($urandom));
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_TICK;
        in_ch.stop_button = 1'b0;
        out_ch.ready      = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = REG_ZONE_RUN_TICKS;
        cfg.data          = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset settings: every command, the refused enable, resume while
        // idle, while paused and while already active, and unused codes.
        queue_cmd(ACT_TICK, 1'b0);
        queue_cmd(ACT_ENABLE, 1'b0);
        queue_cmd(ACT_TICK, 1'b0);
        queue_cmd(ACT_TICK, 1'b0);
        queue_cmd(ACT_PAUSE, 1'b0);
        queue_cmd(ACT_ENABLE, 1'b1);
        queue_cmd(ACT_TICK, 1'b1);
        queue_cmd(ACT_RESUME, 1'b0);
        queue_cmd(ACT_RESUME, 1'b1);
        queue_cmd(ACT_ENABLE, 1'b0);
        queue_cmd(ACT_TICK, 1'b0);
        queue_cmd(ACT_DISABLE, 1'b0);
        queue_cmd(ACT_RESUME, 1'b0);
        queue_cmd(ACT_TICK, 1'b0);
        queue_cmd(ACT_RSVD_FIRST, 1'b0);
        queue_cmd(ACT_RSVD_LAST, 1'b1);
        queue_cmd(ACT_RSVD_FIRST + 3'd1, 1'b1);
        queue_cmd(ACT_PAUSE, 1'b1);
        queue_cmd(ACT_DISABLE, 1'b0);
        queue_cmd(ACT_TICK, 1'b1);

        // Short zones and a short hold: full cycles and forced resets both happen often.
        set_registers(16'd3, 16'd4, 5'd3);
        queue_traffic(50);

        // Low extremes: zone time zero advances every tick, hold time zero resets at once.
        set_registers(16'd0, 16'd0, 5'd1);
        queue_traffic(40);

        // High extremes: nothing advances and the button never reaches its threshold.
        set_registers(16'hFFFF, 16'hFFFF, 5'd16);
        queue_traffic(25);

        // Zone count zero runs a single zone. The receiver holds off here so the block
        // fills up and pushes back on its input.
        set_registers(16'd1, 16'd2, 5'd0);
        holdoff_asked = holdoff_asked + 1;
        queue_traffic(50);

        // A count past the relay width runs all sixteen zones; no idling on either side.
        set_registers(16'd2, 16'd6, 5'd31);
        wait_drained();
        calm = 1'b1;
        queue_traffic(70);
        wait_drained();
        calm = 1'b0;

        // Lowering the zone time in the middle of a zone drives the ratio past full.
        set_registers(16'd60, 16'd40, 5'd4);
        queue_cmd(ACT_ENABLE, 1'b0);
        for (int i = 0; i < 45; i++)
            queue_cmd(ACT_TICK, 1'b0);
        set_registers(16'd7, 16'd40, 5'd4);
        for (int i = 0; i < 4; i++)
            queue_cmd(ACT_TICK, 1'b0);
        queue_traffic(30);

        set_registers(16'd5, 16'd3, 5'd20);
        queue_traffic(50);

        for (int p = 0; p < 2; p++)
        begin
            set_registers(16'($urandom_range(12)), 16'($urandom_range(10)),
                          5'($urandom_range(31)));
            queue_traffic(45);
        end

        wait_drained();
        repeat (SETTLE_LEN) @(posedge clk);
        if (fail_count == 0 && owed_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
